// File: sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Every assertion is clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge outside reset.
`define RCL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal holds while a stalled word waits.
`define RCL_ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

// File: sv/rcl_pkg.sv
// Shared types, constants and functions of the RTC command link.
// No dependencies; every design module imports this package, the checker does not.
`timescale 1ns / 1ps

package rcl_pkg;

    localparam int FRAME_LEN   = 7;
    localparam int PAYLOAD_LEN = 5;
    localparam int IDX_W       = 3;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [1:0] ACT_BYTE   = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_BUTTON = 2'd2;

    localparam logic [7:0]  ACK_CODE   = 8'h05;
    localparam logic [7:0]  NACK_CODE  = 8'h15;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  ASCII_ZERO = 8'd48;

    localparam logic [7:0] CMD_READ  = 8'h31;
    localparam logic [7:0] CMD_WRITE = 8'h32;
    localparam logic [7:0] SUB_VER   = 8'h30;
    localparam logic [7:0] SUB_TIME  = 8'h31;
    localparam logic [7:0] SUB_DATE  = 8'h32;
    localparam logic [7:0] SUB_WAKE  = 8'h33;

    localparam logic [7:0] SEC_MAX  = 8'd59;
    localparam logic [7:0] MIN_MAX  = 8'd59;
    localparam logic [7:0] HOUR_MAX = 8'd23;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_TICK   = 2'd1,
        OP_BUTTON = 2'd2
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic [FRAME_LEN-1:0][7:0]   frame;
    } cmd_t;

    // One byte of reflected CRC-16, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
        logic [15:0] c;
        c = crc_in;
        for (int b = 0; b < 8; b++) begin
            if (c[0] ^ d[b])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [7:0] month_days(input logic [7:0] month, input logic [7:0] year);
        logic [7:0] len;
        case (month)
            8'd2:    len = (year[1:0] == 2'd0) ? 8'd29 : 8'd28;
            8'd4:    len = 8'd30;
            8'd6:    len = 8'd30;
            8'd9:    len = 8'd30;
            8'd11:   len = 8'd30;
            default: len = 8'd31;
        endcase
        return len;
    endfunction

endpackage

// File: sv/rcl_front.sv
// Front end: gathers serial bytes into frames and classifies words into commands.
// Depends on rcl_pkg; feeds rcl_queue.
`timescale 1ns / 1ps

module rcl_front
    import rcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [7:0] rx_byte,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic [IDX_W-1:0] rx_count_reg, rx_count_next;
    logic [7:0]       frame_reg [FRAME_LEN-1];
    logic             accept;
    logic             frame_done;

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign frame_done = (rx_count_reg == IDX_W'(FRAME_LEN - 1));

    always_comb
    begin
        rx_count_next = rx_count_reg;
        q_push        = 1'b0;
        q_cmd.op      = OP_FRAME;
        for (int i = 0; i < FRAME_LEN - 1; i++)
            q_cmd.frame[i] = frame_reg[i];
        q_cmd.frame[FRAME_LEN-1] = rx_byte;
        if (accept)
        begin
            case (action)
                ACT_BYTE:
                begin
                    if (frame_done)
                    begin
                        rx_count_next = '0;
                        q_push        = 1'b1;
                    end
                    else
                        rx_count_next = rx_count_reg + 1'b1;
                end
                ACT_TICK:
                begin
                    q_push   = 1'b1;
                    q_cmd.op = OP_TICK;
                end
                ACT_BUTTON:
                begin
                    q_push   = 1'b1;
                    q_cmd.op = OP_BUTTON;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rx_count_reg <= '0;
        else
            rx_count_reg <= rx_count_next;
    end

    // Hold the bytes of the frame in progress.
    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_BYTE && !frame_done)
            frame_reg[rx_count_reg] <= rx_byte;
    end

endmodule

// File: sv/rcl_queue.sv
// Short command queue between the front end and the back end.
// Depends on rcl_pkg for the command word type and depth.
`timescale 1ns / 1ps

module rcl_queue
    import rcl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: sv/rcl_back.sv
// Back end: checks frame CRCs, runs commands, keeps the clock, calendar and alarm,
// and drives the registered output word. Depends on rcl_pkg; fed by rcl_queue.
`timescale 1ns / 1ps

module rcl_back
    import rcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] tx_byte,
    output logic       alarm_active,
    output logic       last
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_CRC_IN    = 8'b0000_0010,
        ST_CHECK     = 8'b0000_0100,
        ST_EXEC      = 8'b0000_1000,
        ST_CRC_OUT   = 8'b0001_0000,
        ST_SEND      = 8'b0010_0000,
        ST_NACK      = 8'b0100_0000,
        ST_TICK_SEND = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       frame_reg [FRAME_LEN];
    logic [7:0]       resp_reg [PAYLOAD_LEN];
    logic [7:0]       resp_next [PAYLOAD_LEN];

    logic [7:0] hour_reg, hour_next, min_reg, min_next, sec_reg, sec_next;
    logic [7:0] day_reg, day_next, month_reg, month_next, year_reg, year_next;
    logic [7:0] whour_reg, whour_next, wmin_reg, wmin_next, wsec_reg, wsec_next;
    logic [7:0] ver_reg, ver_next, rev_reg, rev_next;

    logic       out_valid_reg, out_valid_next;
    logic       emit, emit_kind, emit_alarm, emit_last;
    logic [7:0] emit_byte;
    logic       load_ok, frame_load;

    // Clock and calendar step for one tick
    logic [8:0] t_sec, t_min, t_hour, t_day;
    logic [7:0] t_len, t_month;
    logic [7:0] a_sec, a_min, a_hour, a_day, a_month, a_year;
    // Alarm minute step for one button press
    logic [8:0] b_min, b_hour;
    logic [7:0] b_wmin, b_whour;

    logic [7:0] crc_in_byte, crc_out_byte, send_resp;
    logic       crc_good;
    logic [7:0] f0, f1;

    assign out_valid    = out_valid_reg;
    assign load_ok      = !out_valid_reg || !out_stall;
    assign f0           = frame_reg[0];
    assign f1           = frame_reg[1];
    assign crc_in_byte  = frame_reg[idx_reg];
    assign crc_good     = (frame_reg[5] == ~crc_reg[15:8]) && (frame_reg[6] == ~crc_reg[7:0]);

    always_comb
    begin
        case (idx_reg)
            3'd0:    crc_out_byte = resp_reg[0];
            3'd1:    crc_out_byte = resp_reg[1];
            3'd2:    crc_out_byte = resp_reg[2];
            3'd3:    crc_out_byte = resp_reg[3];
            default: crc_out_byte = resp_reg[4];
        endcase
        case (idx_reg)
            3'd1:    send_resp = resp_reg[0];
            3'd2:    send_resp = resp_reg[1];
            3'd3:    send_resp = resp_reg[2];
            3'd4:    send_resp = resp_reg[3];
            default: send_resp = resp_reg[4];
        endcase
    end

    always_comb
    begin
        t_sec   = {1'b0, sec_reg} + 9'd1;
        t_min   = {1'b0, min_reg} + 9'd1;
        t_hour  = {1'b0, hour_reg} + 9'd1;
        t_day   = {1'b0, day_reg} + 9'd1;
        t_len   = month_days(month_reg, year_reg);
        t_month = month_reg;
        a_sec   = sec_reg;
        a_min   = min_reg;
        a_hour  = hour_reg;
        a_day   = day_reg;
        a_month = month_reg;
        a_year  = year_reg;
        if (t_sec <= {1'b0, SEC_MAX})
            a_sec = t_sec[7:0];
        else
        begin
            a_sec = '0;
            if (t_min <= {1'b0, MIN_MAX})
                a_min = t_min[7:0];
            else
            begin
                a_min = '0;
                if (t_hour <= {1'b0, HOUR_MAX})
                    a_hour = t_hour[7:0];
                else
                begin
                    a_hour = '0;
                    a_day  = t_day[7:0];
                    if (t_day > {1'b0, t_len})
                    begin
                        a_day   = 8'd1;
                        t_month = month_reg + 8'd1;
                    end
                    a_month = t_month;
                    if (t_month > 8'd12)
                    begin
                        a_month = 8'd1;
                        a_year  = year_reg + 8'd1;
                        a_day   = 8'd1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        b_min   = {1'b0, wmin_reg} + 9'd1;
        b_hour  = {1'b0, whour_reg} + 9'd1;
        b_wmin  = wmin_reg;
        b_whour = whour_reg;
        if (b_min <= {1'b0, MIN_MAX})
            b_wmin = b_min[7:0];
        else
        begin
            b_wmin  = '0;
            b_whour = (b_hour > {1'b0, HOUR_MAX}) ? 8'd0 : b_hour[7:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        q_pop      = 1'b0;
        frame_load = 1'b0;
        for (int i = 0; i < PAYLOAD_LEN; i++)
            resp_next[i] = resp_reg[i];
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        whour_next = whour_reg;
        wmin_next  = wmin_reg;
        wsec_next  = wsec_reg;
        ver_next   = ver_reg;
        rev_next   = rev_reg;
        emit       = 1'b0;
        emit_kind  = 1'b0;
        emit_byte  = '0;
        emit_alarm = 1'b0;
        emit_last  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        OP_FRAME:
                        begin
                            frame_load = 1'b1;
                            crc_next   = CRC_INIT;
                            idx_next   = '0;
                            state_next = ST_CRC_IN;
                        end
                        OP_TICK:
                        begin
                            sec_next   = a_sec;
                            min_next   = a_min;
                            hour_next  = a_hour;
                            day_next   = a_day;
                            month_next = a_month;
                            year_next  = a_year;
                            state_next = ST_TICK_SEND;
                        end
                        OP_BUTTON:
                        begin
                            wmin_next  = b_wmin;
                            whour_next = b_whour;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CRC_IN:
            begin
                crc_next = crc_byte(crc_reg, crc_in_byte);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(PAYLOAD_LEN - 1))
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = crc_good ? ST_EXEC : ST_NACK;
            end
            ST_EXEC:
            begin
                if (f0 == CMD_READ)
                begin
                    resp_next[0] = f0;
                    resp_next[1] = f1;
                    case (f1)
                        SUB_VER:
                        begin
                            resp_next[2] = ver_reg;
                            resp_next[3] = rev_reg;
                            resp_next[4] = FILL_BYTE;
                        end
                        SUB_TIME:
                        begin
                            resp_next[2] = hour_reg;
                            resp_next[3] = min_reg;
                            resp_next[4] = sec_reg;
                        end
                        SUB_DATE:
                        begin
                            resp_next[2] = day_reg;
                            resp_next[3] = month_reg;
                            resp_next[4] = year_reg;
                        end
                        SUB_WAKE:
                        begin
                            resp_next[2] = whour_reg;
                            resp_next[3] = wmin_reg;
                            resp_next[4] = wsec_reg;
                        end
                        default: ;
                    endcase
                end
                else if (f0 == CMD_WRITE)
                begin
                    for (int i = 0; i < PAYLOAD_LEN; i++)
                        resp_next[i] = frame_reg[i];
                    case (f1)
                        SUB_VER:
                        begin
                            ver_next = frame_reg[2] - ASCII_ZERO;
                            rev_next = frame_reg[3] - ASCII_ZERO;
                        end
                        SUB_TIME:
                        begin
                            hour_next = frame_reg[2] - ASCII_ZERO;
                            min_next  = frame_reg[3] - ASCII_ZERO;
                            sec_next  = frame_reg[4] - ASCII_ZERO;
                        end
                        SUB_DATE:
                        begin
                            day_next   = frame_reg[2] - ASCII_ZERO;
                            month_next = frame_reg[3] - ASCII_ZERO;
                            year_next  = frame_reg[4] - ASCII_ZERO;
                        end
                        SUB_WAKE:
                        begin
                            whour_next = frame_reg[2] - ASCII_ZERO;
                            wmin_next  = frame_reg[3] - ASCII_ZERO;
                            wsec_next  = frame_reg[4] - ASCII_ZERO;
                        end
                        default: ;
                    endcase
                end
                crc_next   = CRC_INIT;
                idx_next   = '0;
                state_next = ST_CRC_OUT;
            end
            ST_CRC_OUT:
            begin
                crc_next = crc_byte(crc_reg, crc_out_byte);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(PAYLOAD_LEN - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                // ACK, five response bytes, then the complemented CRC high byte first
                case (idx_reg)
                    3'd0:    emit_byte = ACK_CODE;
                    3'd6:    emit_byte = ~crc_reg[15:8];
                    3'd7:    emit_byte = ~crc_reg[7:0];
                    default: emit_byte = send_resp;
                endcase
                emit_last = (idx_reg == IDX_W'(FRAME_LEN));
                if (load_ok)
                begin
                    emit     = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (emit_last)
                        state_next = ST_IDLE;
                end
            end
            ST_NACK:
            begin
                emit_byte = NACK_CODE;
                emit_last = 1'b1;
                if (load_ok)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_SEND:
            begin
                emit_kind  = 1'b1;
                emit_alarm = (wmin_reg == min_reg) && (whour_reg == hour_reg);
                emit_last  = 1'b1;
                if (load_ok)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PAYLOAD_LEN; i++)
                resp_reg[i] <= '0;
            hour_reg  <= 8'd23;
            min_reg   <= 8'd59;
            sec_reg   <= 8'd40;
            day_reg   <= 8'd28;
            month_reg <= 8'd2;
            year_reg  <= 8'd18;
            whour_reg <= '0;
            wmin_reg  <= '0;
            wsec_reg  <= '0;
            ver_reg   <= 8'd1;
            rev_reg   <= 8'd2;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < PAYLOAD_LEN; i++)
                resp_reg[i] <= resp_next[i];
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            whour_reg <= whour_next;
            wmin_reg  <= wmin_next;
            wsec_reg  <= wsec_next;
            ver_reg   <= ver_next;
            rev_reg   <= rev_next;
        end
    end

    // Hold the frame under work and the output word.
    always_ff @(posedge clk)
    begin
        if (frame_load)
            for (int i = 0; i < FRAME_LEN; i++)
                frame_reg[i] <= q_head.frame[i];
        if (emit)
        begin
            kind         <= emit_kind;
            tx_byte      <= emit_byte;
            alarm_active <= emit_alarm;
            last         <= emit_last;
        end
    end

endmodule

// File: sv/rtc_alarm_crc_command_link.sv
// Top level of the RTC command link: front end, command queue and back end.
// Depends on rcl_pkg, rcl_front, rcl_queue and rcl_back.
//
// Input channel (in_valid / in_stall): one word per action: a received serial
// byte, a one-second tick or an alarm-set button press. Seven bytes make a
// frame: five payload bytes and a CRC-16/X-25, high byte first.
// Output channel (out_valid / out_stall): words of kind 0 carry a byte to send
// (NACK alone, or ACK, five response bytes and their CRC); kind 1 carries the
// alarm level after a tick. last marks the final word of the reply to a frame or tick.
// Flow: the back end picks a command from the queue, runs a byte-wide CRC over
// the five payload bytes, checks it, executes the command and runs the CRC over
// the five response bytes; the eight output bytes then follow at one per cycle
// while out_stall stays low. A tick steps the clock when it is picked and is then
// sent as one alarm word; a button press steps the alarm minute and sends nothing.
// The two-entry queue lets the front keep taking bytes while a frame is worked
// on; in_stall rises only when the queue is full. A stalled output word holds
// and the back end waits in place. Reset clears the queue and loads the clock,
// calendar and alarm with their start values.
`timescale 1ns / 1ps

module rtc_alarm_crc_command_link
    import rcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] tx_byte,
    output logic       alarm_active,
    output logic       last
);

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_cmd, q_head;

    rcl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    rcl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    rcl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .tx_byte      (tx_byte),
        .alarm_active (alarm_active),
        .last         (last)
    );

endmodule

// File: sv/rcl_checker.sv
// Port-level checks of the RTC command link, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rcl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       kind,
    input logic [7:0] tx_byte,
    input logic       alarm_active,
    input logic       last
);

    `RCL_ASSERT_HOLD(a_out_hold, out_valid && out_stall, tx_byte, "stalled output word changed")
    `RCL_ASSERT(a_tick_last, (out_valid && kind) |-> last, "alarm word not marked last")
    `RCL_ASSERT(a_tick_zero, (out_valid && kind) |-> (tx_byte == 8'h00), "alarm word carries a byte")
    `RCL_ASSERT(a_byte_alarm, (out_valid && !kind) |-> !alarm_active, "byte word shows alarm")

endmodule

bind rtc_alarm_crc_command_link rcl_checker u_checker (.*);
